FILE: rtl/core/aasa_pkg.sv
// ----------------------------------------------------------------------------
// aasa_pkg
// Shared constants, types and helpers of the aligned audio source averager.
// ----------------------------------------------------------------------------
package aasa_pkg;

	localparam int SOURCES     = 8;
	localparam int FIFO_DEPTH  = 1024;
	localparam int QUEUE_DEPTH = 4;

	localparam int SRC_W    = 3;
	localparam int SAMPLE_W = 16;
	localparam int MASK_W   = 8;
	localparam int LIMIT_W  = 11;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	localparam int PTR_W     = $clog2(FIFO_DEPTH);
	localparam int FILL_W    = $clog2(FIFO_DEPTH + 1);
	localparam int CNT_W     = $clog2(SOURCES + 1);
	localparam int SUM_W     = SAMPLE_W + $clog2(SOURCES);
	localparam int DIV_SHIFT = SUM_W + $clog2(SOURCES);
	localparam int REC_W     = DIV_SHIFT + 1;
	localparam int PROD_W    = SUM_W + REC_W;
	localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W     = (FILL_W > LIMIT_W) ? FILL_W : LIMIT_W;
	localparam int EXT_W     = (SOURCES > MASK_W) ? SOURCES : MASK_W;

	localparam logic [MASK_W-1:0]  MASK_RESET  = MASK_W'(1);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

	typedef enum logic [0:0] {
		REG_ACTIVE_MASK  = 1'b0,
		REG_RESYNC_LIMIT = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_TAKE,
		ST_READ,
		ST_SUM,
		ST_DIV,
		ST_EMIT
	} state_t;

	// one accepted word as it travels from front to back
	typedef struct packed {
		logic [SRC_W-1:0]           source;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       keep;
	} word_t;

	function automatic logic [SOURCES-1:0] usable_mask(input logic [MASK_W-1:0] mask);
		logic [EXT_W-1:0] ext;
		ext = EXT_W'(mask);
		return ext[SOURCES-1:0];
	endfunction

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

FILE: rtl/core/aligned_audio_source_averager_top.sv
// a sample word passes the queue and the back states; a stalled output holds emit
// throughput: 1 word per cycle while in take with no mix; a mix holds the back
// the back sequencer sets the rate: take, read banks, sum, reciprocal multiply, emit
// a 4-word queue lets the input keep flowing while the back is busy, until it fills
// reset clears fills, pointers, queue, output valid; mask to 1, resync limit to 16
// sample memory has no reset, it is only read where it has been written
// ----------------------------------------------------------------------------
// aligned_audio_source_averager_top
// Averages aligned samples from per-source fifos, with resync flushing.
// ----------------------------------------------------------------------------
module aligned_audio_source_averager_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [aasa_pkg::ADDR_W-1:0]          paddr,
	input  logic [aasa_pkg::DATA_W-1:0]          pwdata,
	output logic [aasa_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic [aasa_pkg::SRC_W-1:0]           source,
	input  logic signed [aasa_pkg::SAMPLE_W-1:0] sample,
	output logic                                 mix_valid,
	input  logic                                 mix_stall,
	output logic signed [aasa_pkg::SAMPLE_W-1:0] mixed_sample,
	output logic [aasa_pkg::MASK_W-1:0]          flushed_mask
);
	import aasa_pkg::*;

	logic [MASK_W-1:0]  mask_q;
	logic [LIMIT_W-1:0] limit_q;
	reg_idx_t           reg_idx;
	logic               wr_en;

	logic  q_full;
	logic  q_push;
	logic  q_pop;
	logic  q_valid;
	word_t q_in;
	word_t q_out;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= MASK_RESET;
			limit_q <= LIMIT_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ACTIVE_MASK:  mask_q  <= pwdata[MASK_W-1:0];
				REG_RESYNC_LIMIT: limit_q <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_ACTIVE_MASK:  prdata = DATA_W'(mask_q);
			REG_RESYNC_LIMIT: prdata = DATA_W'(limit_q);
			default:          prdata = '0;
		endcase
	end

	aasa_front u_front (
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.source       (source),
		.sample       (sample),
		.active_mask  (mask_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_word       (q_in)
	);

	aasa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.word_in  (q_in),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.word_out (q_out)
	);

	aasa_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.active_mask  (mask_q),
		.resync_limit (limit_q),
		.q_valid      (q_valid),
		.q_word       (q_out),
		.q_pop        (q_pop),
		.mix_valid    (mix_valid),
		.mix_stall    (mix_stall),
		.mixed_sample (mixed_sample),
		.flushed_mask (flushed_mask)
	);

endmodule

FILE: rtl/core/aasa_ram.sv
// ----------------------------------------------------------------------------
// aasa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module aasa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/aasa_queue.sv
// ----------------------------------------------------------------------------
// aasa_queue
// Short queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
module aasa_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  aasa_pkg::word_t word_in,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output aasa_pkg::word_t word_out
);
	import aasa_pkg::*;

	word_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	function automatic logic [QPTR_W-1:0] qnext(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign valid    = (count_q != '0);
	assign word_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= word_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= qnext(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= qnext(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/aasa_front.sv
// ----------------------------------------------------------------------------
// aasa_front
// Accepts sample words and tags each with whether its source is in range and active.
// ----------------------------------------------------------------------------
module aasa_front (
	input  logic                         sample_valid,
	output logic                         sample_stall,
	input  logic [aasa_pkg::SRC_W-1:0]   source,
	input  logic signed [aasa_pkg::SAMPLE_W-1:0] sample,
	input  logic [aasa_pkg::MASK_W-1:0]  active_mask,
	input  logic                         q_full,
	output logic                         q_push,
	output aasa_pkg::word_t              q_word
);
	import aasa_pkg::*;

	logic in_range;

	// words for inactive sources still go through, they trigger a mix attempt
	assign in_range       = (int'(source) < SOURCES);
	assign sample_stall   = q_full;
	assign q_push         = sample_valid && !q_full;
	assign q_word.source  = source;
	assign q_word.sample  = sample;
	assign q_word.keep    = in_range && active_mask[source];

endmodule

FILE: rtl/core/aasa_back.sv
// ----------------------------------------------------------------------------
// aasa_back
// Per-source fifo control, aligned pop, averaging divide and resync flush.
// ----------------------------------------------------------------------------
module aasa_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [aasa_pkg::MASK_W-1:0]          active_mask,
	input  logic [aasa_pkg::LIMIT_W-1:0]         resync_limit,
	input  logic                                 q_valid,
	input  aasa_pkg::word_t                      q_word,
	output logic                                 q_pop,
	output logic                                 mix_valid,
	input  logic                                 mix_stall,
	output logic signed [aasa_pkg::SAMPLE_W-1:0] mixed_sample,
	output logic [aasa_pkg::MASK_W-1:0]          flushed_mask
);
	import aasa_pkg::*;

	state_t state_q, state_d;

	logic [FILL_W-1:0]   fill_q [SOURCES];
	logic [PTR_W-1:0]    rp_q   [SOURCES];
	logic [PTR_W-1:0]    wp_q   [SOURCES];
	logic [SAMPLE_W-1:0] rd_data [SOURCES];

	logic [SOURCES-1:0]  m;
	logic [SOURCES-1:0]  wr_bank;
	logic [SOURCES-1:0]  ready;
	logic [SOURCES-1:0]  flush_vec;
	logic                mix_ok;
	logic                rd_phase;
	logic                emit_load;
	logic [CNT_W-1:0]    active_cnt;

	logic signed [SUM_W-1:0] sum;
	logic [SUM_W-1:0]        abs_val;
	logic [SAMPLE_W:0]       quo;
	logic [SAMPLE_W:0]       res;

	logic [CNT_W-1:0]    count_q;
	logic [SUM_W-1:0]    abs_q;
	logic                neg_q;
	logic [MASK_W-1:0]   flushed_q;
	logic [PROD_W-1:0]   prod_q;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] mixed_q;
	logic [MASK_W-1:0]   flush_out_q;

	logic [REC_W-1:0]    recip_tab [SOURCES+1];

	assign m = usable_mask(active_mask);

	// reciprocals rounded up, exact truncated quotient for any sum magnitude
	assign recip_tab[0] = '0;
	for (genvar D = 1; D <= SOURCES; D++) begin : g_recip
		localparam longint unsigned Rv =
			((longint'(1) << DIV_SHIFT) + longint'(D) - 1) / longint'(D);
		assign recip_tab[D] = REC_W'(Rv);
	end

	for (genvar i = 0; i < SOURCES; i++) begin : g_bank
		assign wr_bank[i] = q_pop && q_word.keep && (int'(q_word.source) == i)
			&& (fill_q[i] != FILL_W'(FIFO_DEPTH));
		assign ready[i]   = (fill_q[i] != '0) || wr_bank[i];
		assign flush_vec[i] = (i != 0) && m[0] && (fill_q[0] == '0) && m[i]
			&& (CMP_W'(fill_q[i]) > CMP_W'(resync_limit));

		aasa_ram #(
			.WIDTH (SAMPLE_W),
			.DEPTH (FIFO_DEPTH)
		) u_bank (
			.clk   (clk),
			.we    (wr_bank[i]),
			.waddr (wp_q[i]),
			.wdata (q_word.sample),
			.re    (rd_phase && m[i]),
			.raddr (rp_q[i]),
			.rdata (rd_data[i])
		);
	end

	assign mix_ok = (m != '0) && ((ready | ~m) == '1);

	always_comb begin
		active_cnt = '0;
		for (int i = 0; i < SOURCES; i++) begin
			active_cnt = active_cnt + CNT_W'(m[i]);
		end
	end

	always_comb begin
		sum = '0;
		for (int i = 0; i < SOURCES; i++) begin
			if (m[i]) begin
				sum = sum + SUM_W'(signed'(rd_data[i]));
			end
		end
		abs_val = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
	end

	assign quo = prod_q[DIV_SHIFT +: SAMPLE_W+1];
	assign res = neg_q ? (SAMPLE_W+1)'(-quo) : quo;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_TAKE: begin
				if (q_valid && mix_ok) begin
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_SUM;
			ST_SUM:  state_d = ST_DIV;
			ST_DIV:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (emit_load) begin
					state_d = ST_TAKE;
				end
			end
			default: state_d = ST_TAKE;
		endcase
	end

	// state outputs
	always_comb begin
		q_pop     = 1'b0;
		rd_phase  = 1'b0;
		emit_load = 1'b0;
		unique case (state_q)
			ST_TAKE: q_pop     = q_valid;
			ST_READ: rd_phase  = 1'b1;
			ST_SUM:  ;
			ST_DIV:  ;
			ST_EMIT: emit_load = !out_valid_q || !mix_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_TAKE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < SOURCES; i++) begin
				fill_q[i] <= '0;
				rp_q[i]   <= '0;
				wp_q[i]   <= '0;
			end
		end else begin
			state_q <= state_d;
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (!mix_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_TAKE: begin
					for (int i = 0; i < SOURCES; i++) begin
						if (wr_bank[i]) begin
							wp_q[i]   <= next_ptr(wp_q[i]);
							fill_q[i] <= fill_q[i] + 1'b1;
						end
					end
				end
				ST_READ: begin
					for (int i = 0; i < SOURCES; i++) begin
						if (m[i]) begin
							rp_q[i]   <= next_ptr(rp_q[i]);
							fill_q[i] <= fill_q[i] - 1'b1;
						end
					end
				end
				ST_SUM: begin
					for (int i = 0; i < SOURCES; i++) begin
						if (flush_vec[i]) begin
							fill_q[i] <= '0;
							rp_q[i]   <= wp_q[i];
						end
					end
				end
				ST_DIV:  ;
				ST_EMIT: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_TAKE && q_pop && mix_ok) begin
			count_q <= active_cnt;
		end
		if (state_q == ST_SUM) begin
			abs_q     <= abs_val;
			neg_q     <= sum[SUM_W-1];
			flushed_q <= MASK_W'(flush_vec);
		end
		if (state_q == ST_DIV) begin
			prod_q <= PROD_W'(abs_q) * PROD_W'(recip_tab[count_q]);
		end
		if (emit_load) begin
			mixed_q     <= res[SAMPLE_W-1:0];
			flush_out_q <= flushed_q;
		end
	end

	assign mix_valid    = out_valid_q;
	assign mixed_sample = mixed_q;
	assign flushed_mask = flush_out_q;

	for (genvar i = 0; i < SOURCES; i++) begin : g_chk
		a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
			fill_q[i] <= FILL_W'(FIFO_DEPTH))
			else $error("fifo fill above depth");
	end

	a_emit_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("word loaded outside emit");

	a_no_flush_src0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !flush_out_q[0])
		else $error("source zero reported flushed");

	a_read_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> $past(state_q == ST_TAKE))
		else $error("read phase without take");

endmodule
